FILE: hw/rtl/cau_pkg.sv
// Package for the complex arithmetic unit: operand width, operation and status
// codes, request and result payload structs. No dependencies.
`timescale 1ns / 1ps
package cau_pkg;

  localparam int DATA_WIDTH = 16;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_SAT  = 2'd1,
    STATUS_DIV0 = 2'd2,
    STATUS_RSVD = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]                 func;
    logic signed [DATA_WIDTH-1:0] a_real;
    logic signed [DATA_WIDTH-1:0] a_imag;
    logic signed [DATA_WIDTH-1:0] b_real;
    logic signed [DATA_WIDTH-1:0] b_imag;
  } cau_req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] res_real;
    logic signed [DATA_WIDTH-1:0] res_imag;
    logic [1:0]                   status;
  } cau_res_t;

endpackage

FILE: hw/rtl/cau_div.sv
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// Depends on nothing; the stall enable is shared with the surrounding pipeline.
`timescale 1ns / 1ps
module cau_div #(
  parameter int NUM_W = 41,
  parameter int DEN_W = 32,
  parameter int TAG_W = 1
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic        [DEN_W-1:0] den,
  input  logic        [TAG_W-1:0] tag_in,
  output logic signed [NUM_W-1:0] quo,
  output logic        [TAG_W-1:0] tag_out
);

  localparam int MAG_W = NUM_W;
  localparam int REM_W = DEN_W + 1;

  logic [MAG_W-1:0] qa   [MAG_W+1];
  logic [REM_W-1:0] rem  [MAG_W+1];
  logic [DEN_W-1:0] dd   [MAG_W+1];
  logic             neg  [MAG_W+1];
  logic [TAG_W-1:0] tag  [MAG_W+1];

  // stage 0: magnitude of the numerator
  always_ff @(posedge clk) begin
    if (en) begin
      qa[0]  <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
      rem[0] <= '0;
      dd[0]  <= den;
      neg[0] <= num[NUM_W-1];
      tag[0] <= tag_in;
    end
  end

  for (genvar s = 0; s < MAG_W; s++) begin : g_stage
    logic [REM_W-1:0] sh;
    logic [REM_W:0]   diff;
    assign sh   = {rem[s][REM_W-2:0], qa[s][MAG_W-1]};
    assign diff = {1'b0, sh} - {2'b0, dd[s]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[REM_W]) begin
          rem[s+1] <= diff[REM_W-1:0];
          qa[s+1]  <= {qa[s][MAG_W-2:0], 1'b1};
        end else begin
          rem[s+1] <= sh;
          qa[s+1]  <= {qa[s][MAG_W-2:0], 1'b0};
        end
        dd[s+1]  <= dd[s];
        neg[s+1] <= neg[s];
        tag[s+1] <= tag[s];
      end
    end
  end

  assign quo     = neg[MAG_W] ? -$signed(qa[MAG_W]) : $signed(qa[MAG_W]);
  assign tag_out = tag[MAG_W];

endmodule

FILE: hw/rtl/complex_arithmetic_unit_top.sv
// Complex arithmetic unit: add, subtract, multiply and divide of Q8.8 complex
// operand pairs, with saturation and divide-by-zero status. Depends on cau_pkg and cau_div.
`timescale 1ns / 1ps
// A fully pipelined unit that accepts one request per cycle while the output is
// not stalled and returns one result per request, in order. Every operation passes
// through 2*DATA_WIDTH+FRAC_BITS+6 register stages (46 at the default widths), set
// by the bit-per-stage divider; all operations travel through the same stages so
// that results leave in request order. A stall holds every stage, and no request
// is taken while a result waits at the output.
module complex_arithmetic_unit_top
  import cau_pkg::*;
#(
  parameter int FRAC_BITS  = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  cau_req_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output cau_res_t out_data
);

  localparam int W    = DATA_WIDTH;
  localparam int PW   = 2 * W + 1;
  localparam int NW   = PW + FRAC_BITS;
  localparam int DW   = 2 * W;
  localparam int DLAT = NW + 1;
  localparam int LAT  = DLAT + 2;

  logic en;
  logic vld [LAT+1];

  // the pipeline advances unless the output holds a result nobody takes
  assign en       = !out_valid || out_ready;
  assign in_ready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i <= LAT; i++) vld[i] <= vld[i-1];
    end
  end

  // stage 1: register operands
  logic [1:0] f1;
  logic signed [W-1:0] ar1, ai1, br1, bi1;
  always_ff @(posedge clk) begin
    if (en) begin
      f1  <= in_data.func;
      ar1 <= W'(in_data.a_real);
      ai1 <= W'(in_data.a_imag);
      br1 <= W'(in_data.b_real);
      bi1 <= W'(in_data.b_imag);
    end
  end

  // stage 2: four cross products, the squared magnitude terms and the add/sub sums
  logic [1:0] f2;
  logic signed [2*W-1:0] p_rr, p_ii, p_ir, p_ri, s_rr, s_ii;
  logic signed [W:0] sa_r, sa_i;
  always_ff @(posedge clk) begin
    if (en) begin
      f2   <= f1;
      p_rr <= ar1 * br1;
      p_ii <= ai1 * bi1;
      p_ir <= ai1 * br1;
      p_ri <= ar1 * bi1;
      s_rr <= br1 * br1;
      s_ii <= bi1 * bi1;
      sa_r <= (f1 == FUNC_SUB) ? (W+1)'(ar1) - (W+1)'(br1) : (W+1)'(ar1) + (W+1)'(br1);
      sa_i <= (f1 == FUNC_SUB) ? (W+1)'(ai1) - (W+1)'(bi1) : (W+1)'(ai1) + (W+1)'(bi1);
    end
  end

  // stage 3: sums, numerators and denominator
  logic [1:0] f3;
  logic signed [NW-1:0] num_r, num_i;
  logic signed [PW-1:0] rr3, ri3;
  logic [DW-1:0] den3;
  always_ff @(posedge clk) begin
    if (en) begin
      f3 <= f2;
      if (f2 == FUNC_MUL) begin
        rr3 <= PW'(p_rr) - PW'(p_ii);
        ri3 <= PW'(p_ir) + PW'(p_ri);
      end else begin
        rr3 <= PW'(sa_r);
        ri3 <= PW'(sa_i);
      end
      num_r <= (NW'(p_rr) + NW'(p_ii)) <<< FRAC_BITS;
      num_i <= (NW'(p_ir) - NW'(p_ri)) <<< FRAC_BITS;
      den3  <= DW'(s_rr) + DW'(s_ii);
    end
  end

  // non-divide results ride alongside the divider as its tag
  localparam int TW = 2 + 2 * PW + 1;
  logic [TW-1:0] tag_in, tag_out;
  logic signed [NW-1:0] q_r, q_i;
  logic [TW-1:0] tag_unused;
  logic signed [PW-1:0] rr3s, ri3s;
  assign rr3s   = (f3 == FUNC_MUL) ? (rr3 >>> FRAC_BITS) : rr3;
  assign ri3s   = (f3 == FUNC_MUL) ? (ri3 >>> FRAC_BITS) : ri3;
  assign tag_in = {f3, rr3s, ri3s, den3 == '0};

  cau_div #(.NUM_W(NW), .DEN_W(DW), .TAG_W(TW)) u_div_r (
    .clk(clk), .en(en), .num(num_r), .den(den3), .tag_in(tag_in),
    .quo(q_r), .tag_out(tag_out)
  );
  cau_div #(.NUM_W(NW), .DEN_W(DW), .TAG_W(TW)) u_div_i (
    .clk(clk), .en(en), .num(num_i), .den(den3), .tag_in(tag_in),
    .quo(q_i), .tag_out(tag_unused)
  );

  // final stage: select, saturate, register output
  logic [1:0] fo;
  logic signed [PW-1:0] tr, ti;
  logic dz;
  logic signed [NW-1:0] vr, vi;
  logic signed [NW-1:0] hi, lo;
  logic sat_r, sat_i;
  cau_res_t res_next;

  assign {fo, tr, ti, dz} = tag_out;
  assign hi = NW'((64'sd1 <<< (W - 1)) - 64'sd1);
  assign lo = -hi - NW'(1);

  always_comb begin
    vr = (fo == FUNC_DIV) ? q_r : NW'(tr);
    vi = (fo == FUNC_DIV) ? q_i : NW'(ti);
    sat_r = (vr > hi) || (vr < lo);
    sat_i = (vi > hi) || (vi < lo);
    res_next = '0;
    if (fo == FUNC_DIV && dz) begin
      res_next.status = STATUS_DIV0;
    end else begin
      res_next.res_real = W'(vr > hi ? hi : (vr < lo ? lo : vr));
      res_next.res_imag = W'(vi > hi ? hi : (vi < lo ? lo : vi));
      res_next.status   = (sat_r || sat_i) ? STATUS_SAT : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_data <= res_next;
  end

endmodule
